>>> rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// Package for the ray/box slab test: widths, register indexes, pipeline types.
// No dependencies.
package rbst_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = COORD_W + 2;          // pos + offset - origin
    localparam int MAG_W   = COORD_W + 1;          // |numerator|
    localparam int DEN_W   = COORD_W;              // |direction|
    localparam int Q_W     = COORD_W - 1;          // quotient bits below saturation
    localparam int REM_W   = COORD_W + 1;          // partial remainder
    localparam int EXT_W   = MAG_W + FRAC_W;       // scaled dividend
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_BOX_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_END_Z   = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NUM_W-1:0]   num_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   bits;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [1:0]  lane;
        logic [DEN_W-1:0] den;
        logic             zero;
        logic             in_slab;
    } axis_t;

endpackage

>>> rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
// Ray versus axis-aligned box, slab method, fully pipelined.
// Depends on rbst_pkg.
//
//  channel  | handshake            | words
//  ---------+----------------------+-------------------------------------------
//  input    | start / busy         | object_pos_*, ray_origin_*, ray_dir_*
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//  result   | done (one cycle)     | hit, t_near, t_far
//
// One word per cycle in. Each item passes through the six restoring dividers,
// one quotient bit per stage (31 stages).
// busy is always low: the pipeline never stalls since results cannot be held.
// rst_n clears the valid chain and the box registers to zero.
module ray_box_slab_test (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rbst_pkg::coord_t        object_pos_x,
    input  rbst_pkg::coord_t        object_pos_y,
    input  rbst_pkg::coord_t        object_pos_z,
    input  rbst_pkg::coord_t        ray_origin_x,
    input  rbst_pkg::coord_t        ray_origin_y,
    input  rbst_pkg::coord_t        ray_origin_z,
    input  rbst_pkg::coord_t        ray_dir_x,
    input  rbst_pkg::coord_t        ray_dir_y,
    input  rbst_pkg::coord_t        ray_dir_z,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  rbst_pkg::coord_t        cfg_data,
    output logic                    done,
    output logic                    hit,
    output rbst_pkg::coord_t        t_near,
    output rbst_pkg::coord_t        t_far
);
    import rbst_pkg::*;

    coord_t box_lo_reg [NUM_AXES];
    coord_t box_hi_reg [NUM_AXES];

    coord_t pos   [NUM_AXES];
    coord_t org   [NUM_AXES];
    coord_t dir   [NUM_AXES];

    // stage 1
    logic   v1_reg;
    num_t   num1_reg [NUM_AXES];
    num_t   num2_reg [NUM_AXES];
    coord_t dir_reg  [NUM_AXES];
    // stage 2
    logic   v2_reg;
    axis_t  ax2_reg [NUM_AXES];
    axis_t  ax2_next [NUM_AXES];
    // divider chain: index 0 is the initial remainder
    logic   pv_reg [Q_W+1];
    axis_t  pipe_reg  [Q_W+1][NUM_AXES];
    axis_t  pipe_next [Q_W+1][NUM_AXES];
    // tail
    logic   v_tl_reg;
    coord_t enter_reg [NUM_AXES];
    coord_t leave_reg [NUM_AXES];
    coord_t enter_next [NUM_AXES];
    coord_t leave_next [NUM_AXES];
    logic   v_red_reg;
    coord_t tn_reg, tf_reg, tn_next, tf_next;
    logic   done_reg, hit_reg;
    coord_t t_near_reg, t_far_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign pos[0] = object_pos_x;  assign pos[1] = object_pos_y;  assign pos[2] = object_pos_z;
    assign org[0] = ray_origin_x;  assign org[1] = ray_origin_y;  assign org[2] = ray_origin_z;
    assign dir[0] = ray_dir_x;     assign dir[1] = ray_dir_y;     assign dir[2] = ray_dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BOX_START_X: box_lo_reg[0] <= cfg_data;
                REG_BOX_START_Y: box_lo_reg[1] <= cfg_data;
                REG_BOX_START_Z: box_lo_reg[2] <= cfg_data;
                REG_BOX_END_X:   box_hi_reg[0] <= cfg_data;
                REG_BOX_END_Y:   box_hi_reg[1] <= cfg_data;
                REG_BOX_END_Z:   box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v_tl_reg  <= 1'b0;
            v_red_reg <= 1'b0;
            done_reg  <= 1'b0;
            for (int s = 0; s <= Q_W; s++)
                pv_reg[s] <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            pv_reg[0] <= v2_reg;
            for (int s = 1; s <= Q_W; s++)
                pv_reg[s] <= pv_reg[s-1];
            v_tl_reg  <= pv_reg[Q_W];
            v_red_reg <= v_tl_reg;
            done_reg  <= v_red_reg;
        end
    end

    // stage 2: magnitudes, signs, zero-direction slab check
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ax2_next[a].lane[0].rem  = num1_reg[a][NUM_W-1] ? MAG_W'(-num1_reg[a])
                                                             : MAG_W'(num1_reg[a]);
            ax2_next[a].lane[1].rem  = num2_reg[a][NUM_W-1] ? MAG_W'(-num2_reg[a])
                                                             : MAG_W'(num2_reg[a]);
            ax2_next[a].lane[0].neg  = num1_reg[a][NUM_W-1] ^ dir_reg[a][COORD_W-1];
            ax2_next[a].lane[1].neg  = num2_reg[a][NUM_W-1] ^ dir_reg[a][COORD_W-1];
            for (int l = 0; l < 2; l++)
            begin
                ax2_next[a].lane[l].bits = '0;
                ax2_next[a].lane[l].q    = '0;
                ax2_next[a].lane[l].ovf  = 1'b0;
            end
            ax2_next[a].den    = dir_reg[a][COORD_W-1] ? DEN_W'(-dir_reg[a])
                                                       : DEN_W'(dir_reg[a]);
            ax2_next[a].zero   = (dir_reg[a] == '0);
            // origin between the planes when the two numerators straddle zero
            ax2_next[a].in_slab = ((num1_reg[a] <= 0) && (num2_reg[a] >= 0)) ||
                                  ((num2_reg[a] <= 0) && (num1_reg[a] >= 0));
        end
    end

    // divider chain: initial remainder and overflow, then one bit per stage
    always_comb
    begin
        logic [EXT_W-1:0] ext;
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] dd;
        logic             ge;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pipe_next[0][a] = ax2_reg[a];
            dd = REM_W'(ax2_reg[a].den);
            for (int l = 0; l < 2; l++)
            begin
                ext = EXT_W'(ax2_reg[a].lane[l].rem) << FRAC_W;
                pipe_next[0][a].lane[l].rem  = REM_W'(ext >> Q_W);
                pipe_next[0][a].lane[l].bits = ext[Q_W-1:0];
                pipe_next[0][a].lane[l].q    = '0;
                pipe_next[0][a].lane[l].ovf  = (REM_W'(ext >> Q_W) >= dd);
            end
        end
        for (int s = 1; s <= Q_W; s++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                pipe_next[s][a] = pipe_reg[s-1][a];
                dd = REM_W'(pipe_reg[s-1][a].den);
                for (int l = 0; l < 2; l++)
                begin
                    r2 = {pipe_reg[s-1][a].lane[l].rem[REM_W-2:0],
                          pipe_reg[s-1][a].lane[l].bits[Q_W-1]};
                    ge = (r2 >= dd);
                    pipe_next[s][a].lane[l].rem  = ge ? (r2 - dd) : r2;
                    pipe_next[s][a].lane[l].bits = pipe_reg[s-1][a].lane[l].bits << 1;
                    pipe_next[s][a].lane[l].q    = {pipe_reg[s-1][a].lane[l].q[Q_W-2:0], ge};
                end
            end
        end
    end

    // tail: sign and saturate, then per-axis entry/exit
    always_comb
    begin
        coord_t t [2];
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (pipe_reg[Q_W][a].lane[l].ovf)
                    t[l] = pipe_reg[Q_W][a].lane[l].neg ? T_MIN : T_MAX;
                else if (pipe_reg[Q_W][a].lane[l].neg)
                    t[l] = -coord_t'({1'b0, pipe_reg[Q_W][a].lane[l].q});
                else
                    t[l] = coord_t'({1'b0, pipe_reg[Q_W][a].lane[l].q});
            end
            if (pipe_reg[Q_W][a].zero)
            begin
                enter_next[a] = pipe_reg[Q_W][a].in_slab ? T_MIN : T_MAX;
                leave_next[a] = pipe_reg[Q_W][a].in_slab ? T_MAX : T_MIN;
            end
            else
            begin
                enter_next[a] = (t[0] < t[1]) ? t[0] : t[1];
                leave_next[a] = (t[0] < t[1]) ? t[1] : t[0];
            end
        end
    end

    always_comb
    begin
        tn_next = enter_reg[0];
        tf_next = leave_reg[0];
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if (enter_reg[a] > tn_next)
                tn_next = enter_reg[a];
            if (leave_reg[a] < tf_next)
                tf_next = leave_reg[a];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            num1_reg[a] <= num_t'(pos[a]) + num_t'(box_lo_reg[a]) - num_t'(org[a]);
            num2_reg[a] <= num_t'(pos[a]) + num_t'(box_hi_reg[a]) - num_t'(org[a]);
            dir_reg[a]  <= dir[a];
            ax2_reg[a]  <= ax2_next[a];
            enter_reg[a] <= enter_next[a];
            leave_reg[a] <= leave_next[a];
        end
        for (int s = 0; s <= Q_W; s++)
            for (int a = 0; a < NUM_AXES; a++)
                pipe_reg[s][a] <= pipe_next[s][a];
        tn_reg     <= tn_next;
        tf_reg     <= tf_next;
        hit_reg    <= (tn_reg <= tf_reg);
        t_near_reg <= tn_reg;
        t_far_reg  <= tf_reg;
    end

    assign done   = done_reg;
    assign hit    = hit_reg;
    assign t_near = t_near_reg;
    assign t_far  = t_far_reg;

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> (t_near <= t_far))
        else $error("hit set with t_near above t_far");

    a_miss_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (t_near > t_far))
        else $error("miss reported with t_near not above t_far");

    a_done_chain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_red_reg))
        else $error("result strobe without item in reduction stage");

endmodule
